### src/ptb_pkg.sv
// ptb_pkg: shared constants, codes and types of the periodic timer bank.
// Used by ptb_divider, ptb_engine and periodic_timer_bank_top.
`default_nettype none

package ptb_pkg;

    localparam int TIMER_COUNT = 16;
    localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CNT_W       = $clog2(TIMER_COUNT + 1);

    localparam int QUANTUM_W   = 10;
    localparam int START_W     = 27;
    localparam int ELAPSED_W   = 16;
    localparam int PERIOD_W    = 20;
    localparam int COUNT_W     = 22;
    localparam int CLOCK_W     = 32;
    localparam int INDEX_W     = 6;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 27;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

    localparam int NEAR_LIMIT = 10000;
    localparam int MINDIFF_W  = 14;
    localparam int NEAR_SHIFT = 4;

    localparam int MAX_RESULTS = 16;
    localparam int K_W         = $clog2(MAX_RESULTS + 1);

    localparam int DIV_NUM_W  = 22;
    localparam int DIV_DEN_W  = 20;
    localparam int DIV_CYCLES = DIV_NUM_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam int PROD_W     = 32;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_REGISTER = 1'b1;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_REG  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_NEW    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REUSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_QUANTUM = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_EV,
        S_TICK_END,
        S_REG_START,
        S_DIV_RND,
        S_FIX,
        S_SRCH_EV,
        S_DECIDE,
        S_DIV_MOD,
        S_REG_EMIT
    } state_t;

    typedef struct packed {
        logic                 opcode;
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic [PERIOD_W-1:0]  period_ms;
        logic [PERIOD_W-1:0]  initial_phase;
    } item_t;

    typedef struct packed {
        logic                valid;
        logic                kind;
        logic                fired;
        logic [INDEX_W-1:0]  timer_index;
        logic [STATUS_W-1:0] status;
        logic [PERIOD_W-1:0] period;
        logic [CLOCK_W-1:0]  clock;
        logic                last;
    } res_t;

endpackage

`default_nettype wire

### src/ptb_divider.sv
// ptb_divider: restoring divider, two quotient bits per cycle.
// Depends on ptb_pkg for widths.
`default_nettype none

module ptb_divider (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [ptb_pkg::DIV_NUM_W-1:0]  num_in,
    input  wire logic [ptb_pkg::DIV_DEN_W-1:0]  den_in,
    output logic                                done,
    output logic [ptb_pkg::DIV_NUM_W-1:0]       quot,
    output logic [ptb_pkg::DIV_DEN_W-1:0]       rem
);

    logic                           active_reg;
    logic                           done_reg;
    logic [ptb_pkg::DIV_CNT_W-1:0]  step_reg;
    logic [ptb_pkg::DIV_NUM_W-1:0]  num_reg;
    logic [ptb_pkg::DIV_DEN_W-1:0]  rem_reg;
    logic [ptb_pkg::DIV_DEN_W-1:0]  den_reg;
    logic [ptb_pkg::DIV_NUM_W-1:0]  num_next;
    logic [ptb_pkg::DIV_DEN_W-1:0]  rem_next;

    always_comb
    begin
        logic [ptb_pkg::DIV_DEN_W:0] trial;
        rem_next = rem_reg;
        num_next = num_reg;
        for (int s = 0; s < 2; s++)
        begin
            trial    = {rem_next, num_next[ptb_pkg::DIV_NUM_W-1]};
            num_next = {num_next[ptb_pkg::DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = ptb_pkg::DIV_DEN_W'(trial - {1'b0, den_reg});
                num_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[ptb_pkg::DIV_DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                step_reg   <= '0;
            end
            else if (active_reg)
            begin
                step_reg <= step_reg + ptb_pkg::DIV_CNT_W'(1);
                if (step_reg == ptb_pkg::DIV_CNT_W'(ptb_pkg::DIV_CYCLES - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num_in;
            rem_reg <= '0;
            den_reg <= den_in;
        end
        else if (active_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = num_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

### src/ptb_engine.sv
// ptb_engine: timer memories and the sequencer that walks them for ticks
// and registrations. Depends on ptb_pkg and ptb_divider.
`default_nettype none

module ptb_engine (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ptb_pkg::item_t                 item,
    input  wire logic                           item_accept,
    output logic                                busy,
    input  wire logic [ptb_pkg::QUANTUM_W-1:0]  quantum,
    input  wire logic [ptb_pkg::START_W-1:0]    start_time,
    output ptb_pkg::res_t                       res,
    input  wire logic                           res_ready
);

    logic [ptb_pkg::PERIOD_W-1:0] period_mem [ptb_pkg::TIMER_COUNT];
    logic [ptb_pkg::COUNT_W-1:0]  count_mem  [ptb_pkg::TIMER_COUNT];

    ptb_pkg::state_t state_reg, state_next;

    logic [ptb_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ptb_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [ptb_pkg::CLOCK_W-1:0]   total_reg, total_next;
    logic [ptb_pkg::ELAPSED_W-1:0] el_reg, el_next;
    logic [ptb_pkg::PERIOD_W-1:0]  p_reg, p_next;
    logic [ptb_pkg::PERIOD_W-1:0]  phase_reg, phase_next;
    logic [ptb_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic [ptb_pkg::PERIOD_W-1:0]  r_reg, r_next;
    logic [ptb_pkg::MINDIFF_W-1:0] mindiff_reg, mindiff_next;
    logic [ptb_pkg::IDX_W-1:0]     best_reg, best_next;
    logic                          found_reg, found_next;
    logic [ptb_pkg::K_W-1:0]       k_reg, k_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [ptb_pkg::IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [ptb_pkg::PERIOD_W-1:0]  pend_period_reg, pend_period_next;
    logic [ptb_pkg::IDX_W-1:0]     ans_idx_reg, ans_idx_next;
    logic [ptb_pkg::STATUS_W-1:0]  ans_status_reg, ans_status_next;

    logic [ptb_pkg::PERIOD_W-1:0]  period_rd_reg;
    logic [ptb_pkg::COUNT_W-1:0]   count_rd_reg;

    logic                          rd_en;
    logic [ptb_pkg::IDX_W-1:0]     rd_addr;
    logic                          pmem_we;
    logic                          cmem_we;
    logic [ptb_pkg::IDX_W-1:0]     wr_addr;
    logic [ptb_pkg::PERIOD_W-1:0]  pmem_wd;
    logic [ptb_pkg::COUNT_W-1:0]   cmem_wd;

    logic                           div_start;
    logic [ptb_pkg::DIV_NUM_W-1:0]  div_num;
    logic [ptb_pkg::DIV_DEN_W-1:0]  div_den;
    logic                           div_done;
    logic [ptb_pkg::DIV_NUM_W-1:0]  div_quot;
    logic [ptb_pkg::DIV_DEN_W-1:0]  div_rem;

    logic [ptb_pkg::QUANTUM_W-1:0] q_eff;
    logic [ptb_pkg::CLOCK_W-1:0]   clock_now;
    logic                          last_idx;
    logic                          full;
    logic [ptb_pkg::COUNT_W-1:0]   cdiff;
    logic                          neg;
    logic                          report;
    logic                          tick_block;
    logic [ptb_pkg::PERIOD_W-1:0]  pdiff;
    logic                          closer;
    logic                          near;
    logic                          reuse;
    logic [ptb_pkg::PROD_W-1:0]    mul_a;
    logic [ptb_pkg::PROD_W-1:0]    mul_b;
    logic [ptb_pkg::PERIOD_W-1:0]  r_fix;
    logic [ptb_pkg::IDX_W-1:0]     idx_inc;

    ptb_divider u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_in (div_num),
        .den_in (div_den),
        .done   (div_done),
        .quot   (div_quot),
        .rem    (div_rem)
    );

    assign q_eff     = (quantum == '0) ? ptb_pkg::QUANTUM_W'(1) : quantum;
    assign clock_now = ptb_pkg::CLOCK_W'(start_time) + total_reg;
    assign last_idx  = (ptb_pkg::CNT_W'(idx_reg) + ptb_pkg::CNT_W'(1)) == cnt_reg;
    assign idx_inc   = idx_reg + ptb_pkg::IDX_W'(1);
    assign full      = cnt_reg == ptb_pkg::CNT_W'(ptb_pkg::TIMER_COUNT);

    // stored counters stay below 2^20, so the sign bit of the difference is exact
    assign cdiff      = count_rd_reg - ptb_pkg::COUNT_W'(el_reg);
    assign neg        = cdiff[ptb_pkg::COUNT_W-1];
    assign report     = neg && (k_reg < ptb_pkg::K_W'(ptb_pkg::MAX_RESULTS));
    assign tick_block = report && pend_valid_reg && !res_ready;

    assign pdiff  = (r_reg > period_rd_reg) ? (r_reg - period_rd_reg)
                                            : (period_rd_reg - r_reg);
    assign closer = pdiff < ptb_pkg::PERIOD_W'(mindiff_reg);
    assign near   = (ptb_pkg::PERIOD_W'(mindiff_reg) << ptb_pkg::NEAR_SHIFT) < r_reg;
    assign reuse  = found_reg && (near || full);

    assign mul_a = ptb_pkg::PROD_W'(div_quot);
    assign mul_b = ptb_pkg::PROD_W'(q_eff);

    always_comb
    begin
        if (prod_reg == '0)
            r_fix = ptb_pkg::PERIOD_W'(q_eff);
        else if (prod_reg > ptb_pkg::PROD_W'(ptb_pkg::PERIOD_MAX))
            r_fix = ptb_pkg::PERIOD_W'(prod_reg - ptb_pkg::PROD_W'(q_eff));
        else
            r_fix = prod_reg[ptb_pkg::PERIOD_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptb_pkg::S_IDLE:
            begin
                if (item_accept)
                begin
                    if (item.opcode == ptb_pkg::OP_REGISTER)
                        state_next = ptb_pkg::S_REG_START;
                    else if (cnt_reg == '0)
                        state_next = ptb_pkg::S_TICK_END;
                    else
                        state_next = ptb_pkg::S_TICK_EV;
                end
            end
            ptb_pkg::S_TICK_EV:
            begin
                if (!tick_block && last_idx)
                    state_next = ptb_pkg::S_TICK_END;
            end
            ptb_pkg::S_TICK_END:
            begin
                if (res_ready)
                    state_next = ptb_pkg::S_IDLE;
            end
            ptb_pkg::S_REG_START:
            begin
                state_next = ptb_pkg::S_DIV_RND;
            end
            ptb_pkg::S_DIV_RND:
            begin
                if (div_done)
                    state_next = ptb_pkg::S_FIX;
            end
            ptb_pkg::S_FIX:
            begin
                if (cnt_reg == '0)
                    state_next = ptb_pkg::S_DECIDE;
                else
                    state_next = ptb_pkg::S_SRCH_EV;
            end
            ptb_pkg::S_SRCH_EV:
            begin
                if (last_idx)
                    state_next = ptb_pkg::S_DECIDE;
            end
            ptb_pkg::S_DECIDE:
            begin
                if (reuse || full)
                    state_next = ptb_pkg::S_REG_EMIT;
                else
                    state_next = ptb_pkg::S_DIV_MOD;
            end
            ptb_pkg::S_DIV_MOD:
            begin
                if (div_done)
                    state_next = ptb_pkg::S_REG_EMIT;
            end
            ptb_pkg::S_REG_EMIT:
            begin
                if (res_ready)
                    state_next = ptb_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ptb_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        total_next       = total_reg;
        el_next          = el_reg;
        p_next           = p_reg;
        phase_next       = phase_reg;
        prod_next        = prod_reg;
        r_next           = r_reg;
        mindiff_next     = mindiff_reg;
        best_next        = best_reg;
        found_next       = found_reg;
        k_next           = k_reg;
        pend_valid_next  = pend_valid_reg;
        pend_idx_next    = pend_idx_reg;
        pend_period_next = pend_period_reg;
        ans_idx_next     = ans_idx_reg;
        ans_status_next  = ans_status_reg;

        rd_en     = 1'b0;
        rd_addr   = '0;
        pmem_we   = 1'b0;
        cmem_we   = 1'b0;
        wr_addr   = idx_reg;
        pmem_wd   = r_reg;
        cmem_wd   = cdiff;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;

        res        = '0;
        res.kind   = ptb_pkg::KIND_TICK;
        res.status = ptb_pkg::ST_NEW;
        res.clock  = clock_now;

        case (state_reg)
            ptb_pkg::S_IDLE:
            begin
                if (item_accept)
                begin
                    el_next         = item.elapsed_ms;
                    p_next          = item.period_ms;
                    phase_next      = item.initial_phase;
                    k_next          = '0;
                    pend_valid_next = 1'b0;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    best_next       = '0;
                    mindiff_next    = ptb_pkg::MINDIFF_W'(ptb_pkg::NEAR_LIMIT);
                    if (item.opcode == ptb_pkg::OP_TICK)
                    begin
                        total_next = total_reg + ptb_pkg::CLOCK_W'(item.elapsed_ms);
                        rd_en      = 1'b1;
                    end
                end
            end
            ptb_pkg::S_TICK_EV:
            begin
                if (!tick_block)
                begin
                    cmem_we = 1'b1;
                    cmem_wd = neg ? ptb_pkg::COUNT_W'(period_rd_reg) : cdiff;
                    if (report)
                    begin
                        // previous expiry goes out, this one is held until the next expiry or the end word
                        k_next           = k_reg + ptb_pkg::K_W'(1);
                        pend_valid_next  = 1'b1;
                        pend_idx_next    = idx_reg;
                        pend_period_next = period_rd_reg;
                        if (pend_valid_reg)
                        begin
                            res.valid       = 1'b1;
                            res.fired       = 1'b1;
                            res.timer_index = ptb_pkg::INDEX_W'(pend_idx_reg);
                            res.period      = pend_period_reg;
                        end
                    end
                    if (!last_idx)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc;
                        idx_next = idx_inc;
                    end
                end
            end
            ptb_pkg::S_TICK_END:
            begin
                res.valid = 1'b1;
                res.last  = 1'b1;
                if (pend_valid_reg)
                begin
                    res.fired       = 1'b1;
                    res.timer_index = ptb_pkg::INDEX_W'(pend_idx_reg);
                    res.period      = pend_period_reg;
                end
            end
            ptb_pkg::S_REG_START:
            begin
                div_start = 1'b1;
                div_num   = ptb_pkg::DIV_NUM_W'(p_reg) + ptb_pkg::DIV_NUM_W'(q_eff >> 1);
                div_den   = ptb_pkg::DIV_DEN_W'(q_eff);
            end
            ptb_pkg::S_DIV_RND:
            begin
                if (div_done)
                    prod_next = mul_a * mul_b;
            end
            ptb_pkg::S_FIX:
            begin
                r_next   = r_fix;
                rd_en    = 1'b1;
                idx_next = '0;
            end
            ptb_pkg::S_SRCH_EV:
            begin
                if (closer)
                begin
                    mindiff_next = ptb_pkg::MINDIFF_W'(pdiff);
                    best_next    = idx_reg;
                    found_next   = 1'b1;
                end
                if (!last_idx)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc;
                    idx_next = idx_inc;
                end
            end
            ptb_pkg::S_DECIDE:
            begin
                if (reuse)
                begin
                    ans_idx_next    = best_reg;
                    ans_status_next = ptb_pkg::ST_REUSED;
                end
                else if (full)
                begin
                    ans_idx_next    = '0;
                    ans_status_next = ptb_pkg::ST_NONE;
                end
                else
                begin
                    div_start = 1'b1;
                    div_num   = ptb_pkg::DIV_NUM_W'(phase_reg);
                    div_den   = r_reg;
                end
            end
            ptb_pkg::S_DIV_MOD:
            begin
                if (div_done)
                begin
                    pmem_we         = 1'b1;
                    cmem_we         = 1'b1;
                    wr_addr         = cnt_reg[ptb_pkg::IDX_W-1:0];
                    pmem_wd         = r_reg;
                    cmem_wd         = ptb_pkg::COUNT_W'(div_rem);
                    cnt_next        = cnt_reg + ptb_pkg::CNT_W'(1);
                    ans_idx_next    = cnt_reg[ptb_pkg::IDX_W-1:0];
                    ans_status_next = ptb_pkg::ST_NEW;
                end
            end
            ptb_pkg::S_REG_EMIT:
            begin
                res.valid       = 1'b1;
                res.kind        = ptb_pkg::KIND_REG;
                res.timer_index = ptb_pkg::INDEX_W'(ans_idx_reg);
                res.status      = ans_status_reg;
                res.period      = r_reg;
                res.last        = 1'b1;
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
    end

    assign busy = state_reg != ptb_pkg::S_IDLE;

    always_ff @(posedge clk)
    begin
        if (pmem_we)
            period_mem[wr_addr] <= pmem_wd;
        if (rd_en)
            period_rd_reg <= period_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmem_we)
            count_mem[wr_addr] <= cmem_wd;
        if (rd_en)
            count_rd_reg <= count_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptb_pkg::S_IDLE;
            cnt_reg        <= '0;
            total_reg      <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            total_reg      <= total_next;
            k_reg          <= k_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        el_reg          <= el_next;
        p_reg           <= p_next;
        phase_reg       <= phase_next;
        prod_reg        <= prod_next;
        r_reg           <= r_next;
        mindiff_reg     <= mindiff_next;
        best_reg        <= best_next;
        pend_idx_reg    <= pend_idx_next;
        pend_period_reg <= pend_period_next;
        ans_idx_reg     <= ans_idx_next;
        ans_status_reg  <= ans_status_next;
    end

endmodule

`default_nettype wire

### src/periodic_timer_bank_top.sv
// periodic_timer_bank_top: ports, configuration registers and output register.
// Depends on ptb_pkg and ptb_engine.
//
//   channel | handshake             | words
//   --------+-----------------------+-----------------------------------------------
//   in      | in_valid / in_stall   | opcode, elapsed_ms, period_ms, initial_phase
//   out     | out_valid / out_stall | kind, fired, timer_index, status,
//           |                       | rounded_period_ms, clock_ms, last
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Tick: one memory read-modify-write per timer in use, then the end word.
// Register: a rounding divide and a search over the timers, then the answer on reuse or
// refusal; when a new timer is made, a second divide for the phase modulo comes first.
// One item in flight; in_stall is high until the last word has entered the output
// register. Output stalls hold the walk only when a word is waiting to go out.
// Reset clears the timer count and running clock; no memory clearing pass.
`default_nettype none

module periodic_timer_bank_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              opcode,
    input  wire logic [ptb_pkg::ELAPSED_W-1:0]     elapsed_ms,
    input  wire logic [ptb_pkg::PERIOD_W-1:0]      period_ms,
    input  wire logic [ptb_pkg::PERIOD_W-1:0]      initial_phase,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   kind,
    output logic                                   fired,
    output logic [ptb_pkg::INDEX_W-1:0]            timer_index,
    output logic [ptb_pkg::STATUS_W-1:0]           status,
    output logic [ptb_pkg::PERIOD_W-1:0]           rounded_period_ms,
    output logic [ptb_pkg::CLOCK_W-1:0]            clock_ms,
    output logic                                   last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ptb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ptb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [ptb_pkg::QUANTUM_W-1:0] quantum_reg;
    logic [ptb_pkg::START_W-1:0]   start_reg;
    logic                          out_valid_reg, out_valid_next;
    ptb_pkg::res_t                 out_word_reg;

    ptb_pkg::item_t item;
    ptb_pkg::res_t  res;
    logic           busy;
    logic           item_accept;
    logic           res_ready;

    assign item.opcode        = opcode;
    assign item.elapsed_ms    = elapsed_ms;
    assign item.period_ms     = period_ms;
    assign item.initial_phase = initial_phase;

    assign in_stall    = busy;
    assign item_accept = in_valid && !busy;
    assign res_ready   = !out_valid_reg || !out_stall;
    assign cfg_ready   = 1'b1;

    ptb_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .item_accept (item_accept),
        .busy        (busy),
        .quantum     (quantum_reg),
        .start_time  (start_reg),
        .res         (res),
        .res_ready   (res_ready)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= ptb_pkg::QUANTUM_W'(1);
            start_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ptb_pkg::CFG_QUANTUM: quantum_reg <= cfg_data[ptb_pkg::QUANTUM_W-1:0];
                ptb_pkg::CFG_START:   start_reg   <= cfg_data[ptb_pkg::START_W-1:0];
                default:              quantum_reg <= quantum_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.valid && res_ready)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
            out_word_reg <= res;
    end

    assign out_valid         = out_valid_reg;
    assign kind              = out_word_reg.kind;
    assign fired             = out_word_reg.fired;
    assign timer_index       = out_word_reg.timer_index;
    assign status            = out_word_reg.status;
    assign rounded_period_ms = out_word_reg.period;
    assign clock_ms          = out_word_reg.clock;
    assign last              = out_word_reg.last;

endmodule

`default_nettype wire

### bench/periodic_timer_bank_top_tb.sv
`timescale 1ns / 100ps
// periodic_timer_bank_top_tb: self-checking bench for the periodic timer bank.
// Sends directed and random tick/register words, predicts every report word in SV
// and checks it field by field. Depends on ptb_pkg and periodic_timer_bank_top.

module periodic_timer_bank_top_tb;

    localparam int          HALF_PERIOD     = 10;
    localparam int          RESET_CYCLES    = 10;
    localparam int          SETTLE_CYCLES   = 80;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          MAX_PRINTS      = 200;
    localparam longint      TIMEOUT_NS      = 40_000_000;
    localparam int unsigned START_MAX       = 86399999;
    localparam int unsigned QUANTUM_HIGH    = 1000;

    typedef struct {
        logic                         kind;
        logic                         fired;
        logic [ptb_pkg::INDEX_W-1:0]  idx;
        logic [ptb_pkg::STATUS_W-1:0] status;
        logic [ptb_pkg::PERIOD_W-1:0] period;
        logic [ptb_pkg::CLOCK_W-1:0]  clock_val;
        logic                         last_flag;
    } report_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    wire                             in_stall;
    logic                            opcode;
    logic [ptb_pkg::ELAPSED_W-1:0]   elapsed_ms;
    logic [ptb_pkg::PERIOD_W-1:0]    period_ms;
    logic [ptb_pkg::PERIOD_W-1:0]    initial_phase;
    wire                             out_valid;
    logic                            out_stall;
    wire                             kind;
    wire                             fired;
    wire [ptb_pkg::INDEX_W-1:0]      timer_index;
    wire [ptb_pkg::STATUS_W-1:0]     status;
    wire [ptb_pkg::PERIOD_W-1:0]     rounded_period_ms;
    wire [ptb_pkg::CLOCK_W-1:0]      clock_ms;
    wire                             last;
    logic                            cfg_valid;
    wire                             cfg_ready;
    logic [ptb_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ptb_pkg::CFG_DATA_W-1:0]  cfg_data;

    // predicted bank state
    int unsigned slot_period [ptb_pkg::TIMER_COUNT];
    int          slot_count  [ptb_pkg::TIMER_COUNT];
    int unsigned slots_used  = 0;
    int unsigned elapsed_sum = 0;
    int unsigned quantum_reg = 1;
    int unsigned start_reg   = 0;

    report_t expected_reports[$];
    int      error_count = 0;
    bit      gaps_on;
    bit      stalls_on;
    bit      hold_off_pending;

    periodic_timer_bank_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (opcode),
        .elapsed_ms        (elapsed_ms),
        .period_ms         (period_ms),
        .initial_phase     (initial_phase),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .fired             (fired),
        .timer_index       (timer_index),
        .status            (status),
        .rounded_period_ms (rounded_period_ms),
        .clock_ms          (clock_ms),
        .last              (last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    function automatic logic [ptb_pkg::ELAPSED_W-1:0] rnd_el();
        return ptb_pkg::ELAPSED_W'($urandom);
    endfunction

    function automatic logic [ptb_pkg::PERIOD_W-1:0] rnd_per();
        return ptb_pkg::PERIOD_W'($urandom);
    endfunction

    function automatic int unsigned round_period(input logic [ptb_pkg::PERIOD_W-1:0] req);
        int unsigned q;
        int unsigned r;
        q = (quantum_reg == 0) ? 1 : quantum_reg;
        r = ((req + q / 2) / q) * q;
        if (r < q)
            r = q;
        if (r > ptb_pkg::PERIOD_MAX)
            r -= q;
        return r;
    endfunction

    function automatic bit nearest_slot(input int unsigned r, output int unsigned best,
                                        output int unsigned closest);
        bit          found;
        int unsigned d;
        int unsigned i;
        found   = 1'b0;
        best    = 0;
        closest = ptb_pkg::NEAR_LIMIT;
        for (i = 0; i < slots_used; i++)
        begin
            d = (r > slot_period[i]) ? r - slot_period[i] : slot_period[i] - r;
            if (d < closest)
            begin
                closest = d;
                best    = i;
                found   = 1'b1;
            end
        end
        return found;
    endfunction

    function automatic void push_report(input logic knd, input logic fr, input int unsigned idx,
                                        input logic [ptb_pkg::STATUS_W-1:0] st,
                                        input int unsigned per);
        report_t rep;
        rep.kind      = knd;
        rep.fired     = fr;
        rep.idx       = ptb_pkg::INDEX_W'(idx);
        rep.status    = st;
        rep.period    = ptb_pkg::PERIOD_W'(per);
        rep.clock_val = start_reg + elapsed_sum;
        rep.last_flag = 1'b0;
        expected_reports.push_back(rep);
    endfunction

    function automatic void predict_word(input logic op,
                                         input logic [ptb_pkg::ELAPSED_W-1:0] el,
                                         input logic [ptb_pkg::PERIOD_W-1:0] per,
                                         input logic [ptb_pkg::PERIOD_W-1:0] ph);
        int unsigned r;
        int unsigned best;
        int unsigned closest;
        int unsigned i;
        int unsigned fired_n;
        int          left;
        bit          found;
        bit          full;
        if (op == ptb_pkg::OP_TICK)
        begin
            elapsed_sum += el;
            fired_n = 0;
            for (i = 0; i < slots_used; i++)
            begin
                left = slot_count[i] - int'(el);
                if (left < 0)
                begin
                    slot_count[i] = slot_period[i];
                    if (fired_n < ptb_pkg::MAX_RESULTS)
                    begin
                        // tick words always carry status zero
                        push_report(ptb_pkg::KIND_TICK, 1'b1, i, ptb_pkg::ST_NEW,
                                    slot_period[i]);
                        fired_n++;
                    end
                end
                else
                    slot_count[i] = left;
            end
            if (fired_n == 0)
                push_report(ptb_pkg::KIND_TICK, 1'b0, 0, ptb_pkg::ST_NEW, 0);
        end
        else
        begin
            r     = round_period(per);
            full  = (slots_used >= ptb_pkg::TIMER_COUNT);
            found = nearest_slot(r, best, closest);
            if (found && (closest * (1 << ptb_pkg::NEAR_SHIFT) < r || full))
                push_report(ptb_pkg::KIND_REG, 1'b0, best, ptb_pkg::ST_REUSED, r);
            else if (!full)
            begin
                slot_period[slots_used] = r;
                slot_count[slots_used]  = ph % r;
                push_report(ptb_pkg::KIND_REG, 1'b0, slots_used, ptb_pkg::ST_NEW, r);
                slots_used++;
            end
            else
                push_report(ptb_pkg::KIND_REG, 1'b0, 0, ptb_pkg::ST_NONE, r);
        end
        expected_reports[expected_reports.size() - 1].last_flag = 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic check_report();
        report_t want;
        if (expected_reports.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word kind %0d index %0d status %0d",
                                      kind, timer_index, status));
            return;
        end
        want = expected_reports.pop_front();
        check_field("kind", 32'(kind), 32'(want.kind));
        check_field("fired", 32'(fired), 32'(want.fired));
        check_field("timer_index", 32'(timer_index), 32'(want.idx));
        check_field("status", 32'(status), 32'(want.status));
        check_field("rounded_period_ms", 32'(rounded_period_ms), 32'(want.period));
        check_field("clock_ms", clock_ms, want.clock_val);
        check_field("last", 32'(last), 32'(want.last_flag));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_report();
    end

    initial
    begin : out_stall_gen
        int stall_left;
        int held;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                stall_left       = 0;
                out_stall <= 1'b1;
                for (held = 0; held < HOLD_OFF_CYCLES; held++)
                    @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
                stall_left--;
            else if (stalls_on && $urandom_range(0, 99) < 25)
            begin
                out_stall <= 1'b1;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                         : $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // called right after a rising edge; in_valid stays high on return unless a gap was taken
    task automatic send_word(input logic op, input logic [ptb_pkg::ELAPSED_W-1:0] el,
                             input logic [ptb_pkg::PERIOD_W-1:0] per,
                             input logic [ptb_pkg::PERIOD_W-1:0] ph);
        int pause;
        in_valid      <= 1'b1;
        opcode        <= op;
        elapsed_ms    <= el;
        period_ms     <= per;
        initial_phase <= ph;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_word(op, el, per, ph);
        if (gaps_on && $urandom_range(0, 99) < 30)
        begin
            pause = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (pause)
                @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_config(input int unsigned quantum, input int unsigned start);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= ptb_pkg::CFG_QUANTUM;
        cfg_data  <= ptb_pkg::CFG_DATA_W'(quantum);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        quantum_reg = quantum & 32'h3FF;
        cfg_index <= ptb_pkg::CFG_START;
        cfg_data  <= ptb_pkg::CFG_DATA_W'(start);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        start_reg = start & 32'h7FF_FFFF;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int count, input int reg_pct, input bit wide);
        logic                          op;
        logic [ptb_pkg::ELAPSED_W-1:0] el;
        logic [ptb_pkg::PERIOD_W-1:0]  per;
        int unsigned                   base;
        int unsigned                   span;
        int unsigned                   v;
        repeat (count)
        begin
            op = ($urandom_range(0, 99) < reg_pct) ? ptb_pkg::OP_REGISTER : ptb_pkg::OP_TICK;
            case ($urandom_range(0, 9))
                0:       el = '0;
                1:       el = '1;
                2, 3:    el = rnd_el();
                default: el = ptb_pkg::ELAPSED_W'($urandom_range(0, 3000));
            endcase
            case ($urandom_range(0, 9))
                0, 1:    per = wide ? rnd_per() : ptb_pkg::PERIOD_W'($urandom_range(0, 60000));
                2, 3, 4: per = ptb_pkg::PERIOD_W'($urandom_range(0, 60000));
                default:
                begin
                    // land close to an existing period to hit the reuse window
                    base = (slots_used == 0) ? 0
                                             : slot_period[$urandom_range(0, slots_used - 1)];
                    span = base / 16 + 500;
                    v    = base + $urandom_range(0, 2 * span);
                    v    = (v > span) ? v - span : 0;
                    per  = (v > ptb_pkg::PERIOD_MAX) ? ptb_pkg::PERIOD_MAX
                                                     : v[ptb_pkg::PERIOD_W-1:0];
                end
            endcase
            send_word(op, el, per, rnd_per());
        end
    endtask

    task automatic test_empty_bank();
        send_word(ptb_pkg::OP_TICK, '0, '0, '0);
        send_word(ptb_pkg::OP_TICK, '1, '1, '1);
        set_config(0, START_MAX);
        send_word(ptb_pkg::OP_REGISTER, '0, '0, '1);
        send_word(ptb_pkg::OP_REGISTER, '1, '0, '0);
        send_word(ptb_pkg::OP_REGISTER, 16'h5555, 20'd5000, 20'd12345);
        send_word(ptb_pkg::OP_REGISTER, 16'hAAAA, 20'd5200, rnd_per());
        send_word(ptb_pkg::OP_REGISTER, '0, 20'd20000, '1);
        send_word(ptb_pkg::OP_TICK, 16'd1, rnd_per(), rnd_per());
        send_word(ptb_pkg::OP_TICK, 16'd3000, rnd_per(), rnd_per());
        send_word(ptb_pkg::OP_TICK, 16'hAAAA, 20'hAAAAA, 20'h55555);
        send_word(ptb_pkg::OP_TICK, 16'h5555, 20'h55555, 20'hAAAAA);
    endtask

    task automatic test_rounding();
        set_config(QUANTUM_HIGH, $urandom_range(0, START_MAX));
        send_word(ptb_pkg::OP_REGISTER, rnd_el(), 20'd1499, rnd_per());
        send_word(ptb_pkg::OP_REGISTER, rnd_el(), 20'd1500, rnd_per());
        send_word(ptb_pkg::OP_REGISTER, rnd_el(), 20'd400, rnd_per());
        send_word(ptb_pkg::OP_TICK, 16'd1500, rnd_per(), rnd_per());
    endtask

    task automatic test_random_partial();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        set_config($urandom_range(1, 50), $urandom_range(0, START_MAX));
        send_random(40, 25, 1'b0);
    endtask

    task automatic test_full_bank();
        logic [ptb_pkg::PERIOD_W-1:0] per;
        int unsigned                  r;
        int unsigned                  best;
        int unsigned                  closest;
        int                           tries;
        set_config(1, $urandom_range(0, START_MAX));
        tries = 0;
        while (slots_used < ptb_pkg::TIMER_COUNT)
        begin
            per = (tries < 500) ? ptb_pkg::PERIOD_W'($urandom_range(0, 60000)) : rnd_per();
            tries++;
            r = round_period(per);
            if (!nearest_slot(r, best, closest) || closest * (1 << ptb_pkg::NEAR_SHIFT) >= r)
                send_word(ptb_pkg::OP_REGISTER, rnd_el(), per, rnd_per());
        end
        // every counter is below the max elapsed, so all sixteen fire
        send_word(ptb_pkg::OP_TICK, '1, rnd_per(), rnd_per());
        send_word(ptb_pkg::OP_REGISTER, rnd_el(),
                  ptb_pkg::PERIOD_W'(slot_period[ptb_pkg::TIMER_COUNT / 2] + 9000), rnd_per());
        set_config(QUANTUM_HIGH, START_MAX);
        send_word(ptb_pkg::OP_REGISTER, rnd_el(), ptb_pkg::PERIOD_MAX, ptb_pkg::PERIOD_MAX);
        send_word(ptb_pkg::OP_REGISTER, rnd_el(), '0, rnd_per());
        send_word(ptb_pkg::OP_TICK, '0, rnd_per(), rnd_per());
    endtask

    task automatic test_backpressure();
        int n;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_config(1, $urandom_range(0, START_MAX));
        hold_off_pending = 1'b1;
        for (n = 0; n < 6; n++)
            send_word(ptb_pkg::OP_TICK, '1, rnd_per(), rnd_per());
        wait_drain();
        send_word(ptb_pkg::OP_REGISTER, rnd_el(), ptb_pkg::PERIOD_W'($urandom_range(0, 60000)),
                  rnd_per());
        send_word(ptb_pkg::OP_TICK, rnd_el(), rnd_per(), rnd_per());
    endtask

    task automatic test_random_full();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        set_config(1023, 0);
        send_random(40, 30, 1'b1);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_config(1, START_MAX);
        send_random(30, 30, 1'b1);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        set_config($urandom_range(1, QUANTUM_HIGH), $urandom_range(0, START_MAX));
        send_random(35, 30, 1'b1);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        opcode           = ptb_pkg::OP_TICK;
        elapsed_ms       = '0;
        period_ms        = '0;
        initial_phase    = '0;
        cfg_valid        = 1'b0;
        cfg_index        = ptb_pkg::CFG_QUANTUM;
        cfg_data         = '0;
        gaps_on          = 1'b0;
        stalls_on        = 1'b0;
        hold_off_pending = 1'b0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_bank();
        test_rounding();
        test_random_partial();
        test_full_bank();
        test_backpressure();
        test_random_full();
        wait_drain();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
